[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define CHECK_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("check failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define CHECK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

[rtl/dsrp_pkg.sv]
// Types, constants and decode tables shared by the reply parser modules.
`timescale 1ns / 1ps

package dsrp_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'h16;
	localparam logic [7:0] CMD_MEASURE = 8'h0B;
	localparam logic [7:0] CMD_STATUS  = 8'h0C;
	localparam logic [7:0] CMD_FACTOR  = 8'h07;
	localparam logic [7:0] CMD_CODES   = 8'h1F;

	localparam logic [7:0] FIRST_DATA_POS = 8'd3;
	localparam logic [7:0] ALARM_POS      = 8'd51;
	localparam logic [3:0] ALARM_INDEX    = 4'd10;
	localparam logic [3:0] LAST_CODE      = 4'd4;
	localparam logic [7:0] LEN_OVERHEAD   = 8'd3;

	localparam logic [7:0] MEAS_POS [10] = '{
		8'd3, 8'd7, 8'd11, 8'd15, 8'd27, 8'd31, 8'd35, 8'd39, 8'd43, 8'd47
	};

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_HEADER,
		ERR_SHORT,
		ERR_SUM,
		ERR_CMD
	} err_t;

	typedef enum logic [1:0] {
		KIND_ERR,
		KIND_MEAS,
		KIND_ONE,
		KIND_CODES
	} kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic       bank;
		err_t       err;
		logic [7:0] cmd;
		kind_t      kind;
		logic [7:0] count;
	} job_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	function automatic logic [7:0] item_pos(input kind_t kind, input logic [3:0] idx);
		logic [7:0] pos;
		pos = FIRST_DATA_POS;
		unique case (kind)
			KIND_MEAS: begin
				if (idx == ALARM_INDEX) begin
					pos = ALARM_POS;
				end else if (idx < ALARM_INDEX) begin
					pos = MEAS_POS[idx];
				end
			end
			KIND_CODES: pos = FIRST_DATA_POS + {3'b000, idx, 1'b0};
			KIND_ONE:   pos = FIRST_DATA_POS;
			KIND_ERR:   pos = FIRST_DATA_POS;
			default:    pos = FIRST_DATA_POS;
		endcase
		return pos;
	endfunction

	function automatic logic [2:0] item_len(input kind_t kind, input logic [3:0] idx);
		logic [2:0] len;
		len = 3'd0;
		unique case (kind)
			KIND_MEAS:  len = (idx == ALARM_INDEX) ? 3'd1 : 3'd4;
			KIND_CODES: len = 3'd2;
			KIND_ONE:   len = 3'd1;
			KIND_ERR:   len = 3'd0;
			default:    len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic item_last(input kind_t kind, input logic [3:0] idx);
		logic last;
		last = 1'b1;
		unique case (kind)
			KIND_MEAS:  last = (idx == ALARM_INDEX);
			KIND_CODES: last = (idx == LAST_CODE);
			KIND_ONE:   last = 1'b1;
			KIND_ERR:   last = 1'b1;
			default:    last = 1'b1;
		endcase
		return last;
	endfunction

endpackage

[rtl/dsrp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module dsrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/dsrp_front.sv]
// Front end: takes reply bytes, fills a frame bank, checks the frame and queues a job.
`timescale 1ns / 1ps

module dsrp_front #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rx_valid,
	output logic                          rx_stall,
	input  logic [7:0]                    rx_byte,
	input  logic                          frame_end,
	output logic                          mem_we,
	output logic [$clog2(FRAME_DEPTH):0]  mem_waddr,
	output logic [7:0]                    mem_wdata,
	output logic                          job_push,
	output dsrp_pkg::job_t                job,
	input  dsrp_pkg::rel_t                rel
);

	import dsrp_pkg::*;

	localparam int AW = $clog2(FRAME_DEPTH);

	logic [7:0] cnt_q;
	logic [7:0] sum_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic [7:0] b2_q;
	logic       bank_q;
	logic [1:0] busy_q;

	logic       accept;
	logic [7:0] cnt_nxt;
	logic [7:0] sum_nxt;
	logic [7:0] h0;
	logic [7:0] h1;
	logic [7:0] h2;
	err_t       err;
	kind_t      kind;

	assign rx_stall = busy_q[bank_q];
	assign accept   = rx_valid && !rx_stall;
	assign cnt_nxt  = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
	assign sum_nxt  = sum_q + rx_byte;

	assign mem_we    = accept && (cnt_q != 8'hFF) && ({1'b0, cnt_q} < 9'(FRAME_DEPTH));
	assign mem_waddr = {bank_q, cnt_q[AW-1:0]};
	assign mem_wdata = rx_byte;

	// Header bytes as seen with the current beat included; missing ones read as zero.
	assign h0 = (cnt_q == 8'd0) ? rx_byte : b0_q;
	assign h1 = (cnt_q == 8'd1) ? rx_byte : ((cnt_q > 8'd1) ? b1_q : 8'd0);
	assign h2 = (cnt_q == 8'd2) ? rx_byte : ((cnt_q > 8'd2) ? b2_q : 8'd0);

	always_comb begin
		err  = ERR_NONE;
		kind = KIND_ERR;
		if (h0 != HEADER_BYTE) begin
			err = ERR_HEADER;
		end else if ({1'b0, cnt_nxt} < ({1'b0, h1} + {1'b0, LEN_OVERHEAD})) begin
			err = ERR_SHORT;
		end else if (sum_nxt != 8'd0) begin
			err = ERR_SUM;
		end else begin
			unique case (h2)
				CMD_MEASURE:           kind = KIND_MEAS;
				CMD_STATUS, CMD_FACTOR: kind = KIND_ONE;
				CMD_CODES:             kind = KIND_CODES;
				default:               err  = ERR_CMD;
			endcase
		end
	end

	assign job_push   = accept && frame_end;
	assign job.bank   = bank_q;
	assign job.err    = err;
	assign job.cmd    = h2;
	assign job.kind   = kind;
	assign job.count  = cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 8'd0;
			sum_q  <= 8'd0;
			bank_q <= 1'b0;
			busy_q <= 2'b00;
		end else begin
			if (accept) begin
				if (frame_end) begin
					cnt_q  <= 8'd0;
					sum_q  <= 8'd0;
					bank_q <= !bank_q;
				end else begin
					cnt_q <= cnt_nxt;
					sum_q <= sum_nxt;
				end
			end
			if (job_push) begin
				busy_q[bank_q] <= 1'b1;
			end
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (cnt_q == 8'd0) begin
				b0_q <= rx_byte;
			end
			if (cnt_q == 8'd1) begin
				b1_q <= rx_byte;
			end
			if (cnt_q == 8'd2) begin
				b2_q <= rx_byte;
			end
		end
	end

endmodule

[rtl/dsrp_queue.sv]
// Two-entry job queue between the front end and the decoder.
`timescale 1ns / 1ps

module dsrp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dsrp_pkg::job_t push_job,
	input  logic           pop,
	output logic           q_valid,
	output logic           q_full,
	output dsrp_pkg::job_t q_job
);

	import dsrp_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign q_valid = (fill_q != 2'd0);
	assign q_full  = (fill_q == 2'd2);
	assign q_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[rtl/dsrp_back.sv]
// Decoder: reads the frame bank byte by byte and emits the run of result beats.
`timescale 1ns / 1ps

module dsrp_back #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  dsrp_pkg::job_t                q_job,
	output logic                          job_pop,
	output logic [$clog2(FRAME_DEPTH):0]  mem_raddr,
	input  logic [7:0]                    mem_rdata,
	output dsrp_pkg::rel_t                rel,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [2:0]                    error_code,
	output logic [7:0]                    command,
	output logic [3:0]                    item_index,
	output logic [31:0]                   item_value,
	output logic                          last_item
);

	import dsrp_pkg::*;

	localparam int AW = $clog2(FRAME_DEPTH);

	bk_state_t   state_q;
	bk_state_t   state_d;
	job_t        job_q;
	logic [3:0]  idx_q;
	logic [2:0]  k_q;
	logic [31:0] acc_q;
	logic        rd_ok_s1;
	logic        res_valid_q;

	logic [7:0]  pos;
	logic [2:0]  len;
	logic        last;
	logic [7:0]  off;
	logic        out_free;
	logic        load_out;
	logic        shift_in;
	logic [7:0]  rd_byte;

	assign pos      = item_pos(job_q.kind, idx_q);
	assign len      = item_len(job_q.kind, idx_q);
	assign last     = item_last(job_q.kind, idx_q);
	assign off      = pos + {5'd0, k_q};
	assign out_free = !res_valid_q || !res_stall;
	assign rd_byte  = rd_ok_s1 ? mem_rdata : 8'd0;

	assign mem_raddr = {job_q.bank, off[AW-1:0]};
	assign res_valid = res_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = (q_job.kind == KIND_ERR) ? BK_OUT : BK_READ;
				end
			end
			BK_READ: begin
				if (k_q == len) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (out_free) begin
					state_d = last ? BK_IDLE : BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		load_out  = 1'b0;
		shift_in  = 1'b0;
		rel.valid = 1'b0;
		rel.bank  = job_q.bank;
		unique case (state_q)
			BK_IDLE: job_pop = q_valid;
			BK_READ: shift_in = (k_q != 3'd0);
			BK_OUT: begin
				load_out  = out_free;
				rel.valid = out_free && last;
			end
			default: job_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= load_out || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		rd_ok_s1 <= (off < job_q.count);
		if (job_pop) begin
			job_q <= q_job;
			idx_q <= 4'd0;
			k_q   <= 3'd0;
			acc_q <= 32'd0;
		end
		if (state_q == BK_READ && k_q != len) begin
			k_q <= k_q + 3'd1;
		end
		if (shift_in) begin
			acc_q <= {acc_q[23:0], rd_byte};
		end
		if (load_out) begin
			error_code <= job_q.err;
			command    <= job_q.cmd;
			item_index <= idx_q;
			item_value <= acc_q;
			last_item  <= last;
			idx_q      <= idx_q + 4'd1;
			k_q        <= 3'd0;
			acc_q      <= 32'd0;
		end
	end

endmodule

[rtl/dust_sensor_reply_parser.sv]
// Top level of the dust sensor reply parser: front end, job queue, decoder and frame RAM.
//
//  channel | handshake            | fields
//  --------+----------------------+----------------------------------------------------
//  rx      | rx_valid, rx_stall   | rx_byte, frame_end
//  res     | res_valid, res_stall | error_code, command, item_index, item_value, last_item
//
// A byte beat is taken every cycle unless the bank it would fill is still queued or being decoded.
// Frames alternate between two RAM banks, so one frame can arrive while the previous one decodes.
// The single RAM read port sets the result rate: an item's bytes are read one at a time before its beat is loaded.
// Unreceived positions read as zero through the stored byte count; no clearing pass is needed.
// A stalled result beat holds in the output register while the next item is being read.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dust_sensor_reply_parser #(
	parameter int FRAME_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  error_code,
	output logic [7:0]  command,
	output logic [3:0]  item_index,
	output logic [31:0] item_value,
	output logic        last_item
);

	import dsrp_pkg::*;

	localparam int AW    = $clog2(FRAME_DEPTH);
	localparam int DEPTH = 2 * (2 ** AW);

	logic          mem_we;
	logic [AW:0]   mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW:0]   mem_raddr;
	logic [7:0]    mem_rdata;
	logic          job_push;
	job_t          job;
	logic          job_pop;
	logic          q_valid;
	logic          q_full;
	job_t          q_job;
	rel_t          rel;

	dsrp_front #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.job_push  (job_push),
		.job       (job),
		.rel       (rel)
	);

	dsrp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.pop      (job_pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.q_job    (q_job)
	);

	dsrp_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	dsrp_back #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_job      (q_job),
		.job_pop    (job_pop),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.rel        (rel),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.error_code (error_code),
		.command    (command),
		.item_index (item_index),
		.item_value (item_value),
		.last_item  (last_item)
	);

	`CHECK_IMPLY(a_push_has_room, clk, arst_n, job_push, !q_full || job_pop)
	`CHECK_IMPLY(a_pop_has_job, clk, arst_n, job_pop, q_valid)
	`CHECK_IMPLY(a_mid_run_ok, clk, arst_n, res_valid && !last_item, error_code == ERR_NONE)
	`CHECK_IMPLY(a_error_beat_form, clk, arst_n, res_valid && error_code != ERR_NONE, item_value == 32'd0 && item_index == 4'd0 && last_item)
	`CHECK_NEXT(a_release_frees_decoder, clk, arst_n, rel.valid, !res_valid || last_item)

endmodule
